### rtl/ppsched_pkg.sv
// Shared types and constants for the preemptive priority scheduler.
// No dependencies; used by every module in rtl/.
package ppsched_pkg;

  localparam int PRIO_W  = 8;
  localparam int ARR_W   = 16;
  localparam int BURST_W = 16;
  localparam int TIME_W  = 24;
  localparam int SUM_W   = 32;
  localparam int SLOT_W  = 4;

  localparam logic [TIME_W-1:0] TIME_MAX = {TIME_W{1'b1}};
  localparam logic [SUM_W-1:0]  SUM_MAX  = {SUM_W{1'b1}};

  // command codes
  localparam logic CMD_LOAD = 1'b0;
  localparam logic CMD_TICK = 1'b1;

  // static part of one process record
  typedef struct packed {
    logic [PRIO_W-1:0]  prio;
    logic [ARR_W-1:0]   arrival;
    logic [BURST_W-1:0] burst;
  } rec_t;

  // table port controls
  typedef struct packed {
    logic rec_we;
    logic rem_we;
    logic rd_en;
  } tbl_ctl_t;

endpackage

### rtl/ppsched_table.sv
// Process table: static record memory plus remaining-burst memory.
// One write port, one registered read port. Depends on ppsched_pkg.
module ppsched_table #(
  parameter int DEPTH = 16,
  parameter int IDX_W = 4
) (
  input  logic                             clk,
  input  ppsched_pkg::tbl_ctl_t            ctl,
  input  logic [IDX_W-1:0]                 wr_addr,
  input  ppsched_pkg::rec_t                rec_wdata,
  input  logic [ppsched_pkg::BURST_W-1:0]  rem_wdata,
  input  logic [IDX_W-1:0]                 rd_addr,
  output ppsched_pkg::rec_t                rd_rec,
  output logic [ppsched_pkg::BURST_W-1:0]  rd_rem
);

  ppsched_pkg::rec_t               rec_mem [DEPTH];
  logic [ppsched_pkg::BURST_W-1:0] rem_mem [DEPTH];

  always_ff @(posedge clk) begin
    if (ctl.rec_we) begin
      rec_mem[wr_addr] <= rec_wdata;
    end
    if (ctl.rem_we) begin
      rem_mem[wr_addr] <= rem_wdata;
    end
    if (ctl.rd_en) begin
      rd_rec <= rec_mem[rd_addr];
      rd_rem <= rem_mem[rd_addr];
    end
  end

endmodule

### rtl/ppsched_cmp.sv
// Shared candidate-versus-best comparator used once per scanned entry.
// Depends on ppsched_pkg.
module ppsched_cmp (
  input  logic                            lower_value_first,
  input  logic                            have_best,
  input  logic [ppsched_pkg::PRIO_W-1:0]  cand_prio,
  input  logic [ppsched_pkg::ARR_W-1:0]   cand_arrival,
  input  logic [ppsched_pkg::PRIO_W-1:0]  best_eff,
  input  logic [ppsched_pkg::ARR_W-1:0]   best_arrival,
  output logic [ppsched_pkg::PRIO_W-1:0]  cand_eff,
  output logic                            take
);

  // 255 - p is the bitwise inverse
  assign cand_eff = lower_value_first ? ~cand_prio : cand_prio;

  assign take = !have_best || (cand_eff > best_eff) ||
                ((cand_eff == best_eff) && (cand_arrival < best_arrival));

endmodule

### rtl/preemptive_priority_scheduler.sv
// Top level of the preemptive priority scheduler: sequencer, scan registers,
// result registers. Depends on ppsched_pkg, ppsched_table, ppsched_cmp.
//
// Usage:
//   Command channel: start/busy. A transaction is taken at a rising edge with
//   start high and busy low. cmd = load appends a process record (priority,
//   arrival, burst) to the table; a load into a full table is dropped. A load
//   leaves busy low and produces no result.
//   cmd = tick advances time one unit. The sequencer walks the loaded entries
//   through the single table read port, one entry per cycle, and feeds each
//   to one shared comparator. The update state and the report state follow.
//   The result strobe comes after the report state, and busy is high through
//   the scan, update and report states; the next command can be taken in the
//   strobe cycle. The scan length is set by the table's one read port.
//   Result channel: result_valid is high for exactly one cycle with all
//   result ports; the receiver cannot stall, so nothing is held back.
//   Config channel: cfg_valid/cfg_ready writes lower_value_first; ready
//   whenever the sequencer is idle. Takes effect at the next tick.
//   Reset (rst, synchronous): empties the table, clears done flags, time,
//   waiting total and the running process. No clearing pass is needed.
module preemptive_priority_scheduler #(
  parameter int MAX_PROCS = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic        cmd,
  input  logic [7:0]  proc_priority,
  input  logic [15:0] proc_arrival,
  input  logic [15:0] proc_burst,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_lower_value_first,
  output logic        result_valid,
  output logic        slot_idle,
  output logic [3:0]  slot_process,
  output logic        finished,
  output logic [23:0] finish_time,
  output logic [23:0] turnaround_time,
  output logic [23:0] wait_time,
  output logic [31:0] wait_total,
  output logic        all_done
);

  localparam int IDX_W = (MAX_PROCS > 1) ? $clog2(MAX_PROCS) : 1;
  localparam int CNT_W = $clog2(MAX_PROCS + 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(MAX_PROCS);

  localparam int PW = ppsched_pkg::PRIO_W;
  localparam int AW = ppsched_pkg::ARR_W;
  localparam int BW = ppsched_pkg::BURST_W;
  localparam int TW = ppsched_pkg::TIME_W;
  localparam int SW = ppsched_pkg::SUM_W;

  typedef enum logic [3:0] {
    ST_IDLE   = 4'b0001,
    ST_SCAN   = 4'b0010,
    ST_UPDATE = 4'b0100,
    ST_REPORT = 4'b1000
  } state_t;

  state_t state;

  // architectural state
  logic                 lower_value_first;
  logic [CNT_W-1:0]     loaded_count;
  logic [CNT_W-1:0]     done_count;
  logic [MAX_PROCS-1:0] done;
  logic [IDX_W-1:0]     running_index;
  logic                 running_valid;
  logic [TW-1:0]        now_time;
  logic [SW-1:0]        wait_sum;

  // scan state
  logic [CNT_W-1:0] scan_cnt;
  logic             rd_valid;
  logic [IDX_W-1:0] rd_idx;
  logic             found;
  logic [IDX_W-1:0] best_idx;
  logic [PW-1:0]    best_eff;
  logic [AW-1:0]    best_arr;
  logic [BW-1:0]    best_burst;
  logic [BW-1:0]    best_rem;
  logic             run_seen;
  logic [PW-1:0]    run_eff;
  logic [AW-1:0]    run_arr;
  logic [BW-1:0]    run_burst;
  logic [BW-1:0]    run_rem;

  // update-to-report registers
  logic             found_q;
  logic             fin_q;
  logic [TW-1:0]    comp_q;
  logic [TW-1:0]    tat_q;
  logic [BW-1:0]    burst_q;
  logic [IDX_W-1:0] slot_q;

  // table interface
  ppsched_pkg::tbl_ctl_t tbl_ctl;
  ppsched_pkg::rec_t     rec_wdata;
  ppsched_pkg::rec_t     rd_rec;
  logic [BW-1:0]         rem_wdata;
  logic [BW-1:0]         rd_rem;
  logic [IDX_W-1:0]      wr_addr;
  logic [IDX_W-1:0]      rd_addr;

  logic          accept;
  logic          load_go;
  logic          issuing;
  logic [BW-1:0] burst_fix;
  logic          elig;
  logic [PW-1:0] cand_eff;
  logic          take;

  logic          use_run;
  logic [IDX_W-1:0] sel_idx;
  logic [AW-1:0] sel_arr;
  logic [BW-1:0] sel_burst;
  logic [BW-1:0] sel_rem;
  logic          sel_last;
  logic [TW-1:0] now_next;
  logic [TW-1:0] tat_c;
  logic [TW-1:0] wt_c;
  logic [SW:0]   sum_c;
  logic [IDX_W+SW-1:0] slot_ext;

  assign busy      = (state != ST_IDLE);
  assign cfg_ready = !busy;
  assign accept    = start && !busy;
  assign load_go   = accept && (cmd == ppsched_pkg::CMD_LOAD) && (loaded_count != CNT_FULL);
  assign issuing   = (state == ST_SCAN) && (scan_cnt < loaded_count);

  // a zero burst is stored as one
  assign burst_fix = (proc_burst == '0) ? BW'(1) : proc_burst;

  assign rec_wdata = '{prio: proc_priority, arrival: proc_arrival, burst: burst_fix};
  assign rd_addr   = scan_cnt[IDX_W-1:0];

  always_comb begin
    tbl_ctl.rd_en  = issuing;
    tbl_ctl.rec_we = load_go;
    tbl_ctl.rem_we = load_go || ((state == ST_UPDATE) && found);
    wr_addr        = (state == ST_UPDATE) ? sel_idx : loaded_count[IDX_W-1:0];
    rem_wdata      = (state == ST_UPDATE) ? sel_rem - BW'(1) : burst_fix;
  end

  ppsched_table #(
    .DEPTH (MAX_PROCS),
    .IDX_W (IDX_W)
  ) u_table (
    .clk       (clk),
    .ctl       (tbl_ctl),
    .wr_addr   (wr_addr),
    .rec_wdata (rec_wdata),
    .rem_wdata (rem_wdata),
    .rd_addr   (rd_addr),
    .rd_rec    (rd_rec),
    .rd_rem    (rd_rem)
  );

  ppsched_cmp u_cmp (
    .lower_value_first (lower_value_first),
    .have_best         (found),
    .cand_prio         (rd_rec.prio),
    .cand_arrival      (rd_rec.arrival),
    .best_eff          (best_eff),
    .best_arrival      (best_arr),
    .cand_eff          (cand_eff),
    .take              (take)
  );

  // entry under compare: arrived and not yet complete
  assign elig = rd_valid && !done[rd_idx] && ({{(TW-AW){1'b0}}, rd_rec.arrival} <= now_time);

  // winner select: running process keeps the CPU on an effective-priority tie
  always_comb begin
    use_run   = found && run_seen && (run_eff == best_eff);
    sel_idx   = use_run ? running_index : best_idx;
    sel_arr   = use_run ? run_arr       : best_arr;
    sel_burst = use_run ? run_burst     : best_burst;
    sel_rem   = use_run ? run_rem       : best_rem;
    sel_last  = (sel_rem <= BW'(1));
    now_next  = (now_time == ppsched_pkg::TIME_MAX) ? now_time : now_time + TW'(1);
    tat_c     = (now_next >= {{(TW-AW){1'b0}}, sel_arr}) ?
                now_next - {{(TW-AW){1'b0}}, sel_arr} : '0;
  end

  // report stage arithmetic
  always_comb begin
    wt_c     = (fin_q && (tat_q >= {{(TW-BW){1'b0}}, burst_q})) ?
               tat_q - {{(TW-BW){1'b0}}, burst_q} : '0;
    sum_c    = {1'b0, wait_sum} + {{(SW+1-TW){1'b0}}, wt_c};
    slot_ext = {{SW{1'b0}}, slot_q};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state             <= ST_IDLE;
      lower_value_first <= 1'b0;
      loaded_count      <= '0;
      done_count        <= '0;
      done              <= '0;
      running_index     <= '0;
      running_valid     <= 1'b0;
      now_time          <= '0;
      wait_sum          <= '0;
      scan_cnt          <= '0;
      rd_valid          <= 1'b0;
      found             <= 1'b0;
      run_seen          <= 1'b0;
      result_valid      <= 1'b0;
    end else begin
      result_valid <= 1'b0;
      rd_valid     <= issuing;
      rd_idx       <= rd_addr;

      if (cfg_valid && cfg_ready) begin
        lower_value_first <= cfg_lower_value_first;
      end

      case (state)
        ST_IDLE: begin
          if (load_go) begin
            done[loaded_count[IDX_W-1:0]] <= 1'b0;
            loaded_count <= loaded_count + CNT_W'(1);
          end
          if (accept && (cmd == ppsched_pkg::CMD_TICK)) begin
            scan_cnt <= '0;
            found    <= 1'b0;
            run_seen <= 1'b0;
            state    <= ST_SCAN;
          end
        end
        ST_SCAN: begin
          if (issuing) begin
            scan_cnt <= scan_cnt + CNT_W'(1);
          end
          if (elig && take) begin
            found      <= 1'b1;
            best_idx   <= rd_idx;
            best_eff   <= cand_eff;
            best_arr   <= rd_rec.arrival;
            best_burst <= rd_rec.burst;
            best_rem   <= rd_rem;
          end
          if (elig && running_valid && (rd_idx == running_index)) begin
            run_seen  <= 1'b1;
            run_eff   <= cand_eff;
            run_arr   <= rd_rec.arrival;
            run_burst <= rd_rec.burst;
            run_rem   <= rd_rem;
          end
          if (!issuing && !rd_valid) begin
            state <= ST_UPDATE;
          end
        end
        ST_UPDATE: begin
          now_time <= now_next;
          found_q  <= found;
          slot_q   <= sel_idx;
          burst_q  <= sel_burst;
          fin_q    <= found && sel_last;
          comp_q   <= (found && sel_last) ? now_next : '0;
          tat_q    <= (found && sel_last) ? tat_c : '0;
          if (found) begin
            running_index <= sel_idx;
            running_valid <= !sel_last;
            if (sel_last) begin
              done[sel_idx] <= 1'b1;
              done_count    <= done_count + CNT_W'(1);
            end
          end else begin
            running_valid <= 1'b0;
          end
          state <= ST_REPORT;
        end
        ST_REPORT: begin
          wait_sum     <= sum_c[SW] ? ppsched_pkg::SUM_MAX : sum_c[SW-1:0];
          result_valid <= 1'b1;
          state        <= ST_IDLE;
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // result registers, loaded in the report cycle
  always_ff @(posedge clk) begin
    if (state == ST_REPORT) begin
      slot_idle       <= !found_q;
      slot_process    <= found_q ? slot_ext[3:0] : 4'd0;
      finished        <= fin_q;
      finish_time     <= comp_q;
      turnaround_time <= tat_q;
      wait_time       <= wt_c;
      wait_total      <= sum_c[SW] ? ppsched_pkg::SUM_MAX : sum_c[SW-1:0];
      all_done        <= (done_count == loaded_count);
    end
  end

  // the strobe only appears once the sequencer is back to idle
  a_strobe_idle: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> (state == ST_IDLE))
    else $error("result strobe outside idle");

  // completions never exceed loads
  a_done_bound: assert property (@(posedge clk) disable iff (rst)
    done_count <= loaded_count)
    else $error("done count above loaded count");

  // a completed slot always names a process
  a_fin_busy_slot: assert property (@(posedge clk) disable iff (rst)
    (result_valid && finished) |-> !slot_idle)
    else $error("finish reported on idle slot");

  // the process kept as running has not completed
  a_run_not_done: assert property (@(posedge clk) disable iff (rst)
    running_valid |-> !done[running_index])
    else $error("running process marked done");

  // update is always followed by the report cycle
  a_update_report: assert property (@(posedge clk) disable iff (rst)
    (state == ST_UPDATE) |=> (state == ST_REPORT))
    else $error("report cycle skipped");

endmodule

### verif/preemptive_priority_scheduler_tb.sv
// Self-checking testbench for preemptive_priority_scheduler: load/tick command traffic,
// policy register writes, and a cycle-free scheduler predictor that checks every slot report.
// Depends on ppsched_pkg and the preemptive_priority_scheduler RTL.
module preemptive_priority_scheduler_tb;
  timeunit 1ns;
  timeprecision 1ps;

  // policy register values
  localparam bit LARGER_WINS  = 1'b0;
  localparam bit SMALLER_WINS = 1'b1;

  localparam int TBL_DEPTH   = 16;
  // settle padding after the last accepted command, before a register write and at the end
  localparam int SETTLE      = 24;
  localparam int WATCHDOG    = 2000;
  localparam int RAND_PHASES = 10;
  localparam int PHASE_ITEMS = 125;

  // one queued stimulus transaction: a command or a policy write
  typedef struct {
    bit          is_cfg;
    bit          cfg_val;
    logic        cmd;
    logic [7:0]  prio;
    logic [15:0] arrival;
    logic [15:0] burst;
  } sched_op_t;

  // one slot report as the scheduler should produce it
  typedef struct {
    bit        idle;
    bit [3:0]  proc_id;
    bit        fin;
    bit [23:0] comp;
    bit [23:0] tat;
    bit [23:0] wt;
    bit [31:0] wsum;
    bit        all_done;
  } slot_report_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        start = 1'b0;
  logic        busy;
  logic        cmd = ppsched_pkg::CMD_TICK;
  logic [7:0]  proc_priority = '0;
  logic [15:0] proc_arrival = '0;
  logic [15:0] proc_burst = 16'd1;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic        cfg_lower_value_first = LARGER_WINS;
  logic        result_valid;
  logic        slot_idle;
  logic [3:0]  slot_process;
  logic        finished;
  logic [23:0] finish_time;
  logic [23:0] turnaround_time;
  logic [23:0] wait_time;
  logic [31:0] wait_total;
  logic        all_done;

  sched_op_t    pending_ops[$];
  slot_report_t slot_expect_q[$];

  int err_count = 0;
  int ops_done = 0;
  int ops_total = 0;
  int stall_cycles = 0;

  preemptive_priority_scheduler u_dut (
    .clk                   (clk),
    .rst                   (rst),
    .start                 (start),
    .busy                  (busy),
    .cmd                   (cmd),
    .proc_priority         (proc_priority),
    .proc_arrival          (proc_arrival),
    .proc_burst            (proc_burst),
    .cfg_valid             (cfg_valid),
    .cfg_ready             (cfg_ready),
    .cfg_lower_value_first (cfg_lower_value_first),
    .result_valid          (result_valid),
    .slot_idle             (slot_idle),
    .slot_process          (slot_process),
    .finished              (finished),
    .finish_time           (finish_time),
    .turnaround_time       (turnaround_time),
    .wait_time             (wait_time),
    .wait_total            (wait_total),
    .all_done              (all_done)
  );

  always #5 clk = ~clk;

  // ------------------------------------------------------------------
  // Scheduler predictor: process table, clock and waiting total
  // ------------------------------------------------------------------
  bit [7:0]  tbl_prio[TBL_DEPTH];
  bit [15:0] tbl_arr[TBL_DEPTH];
  bit [15:0] tbl_burst[TBL_DEPTH];
  bit [15:0] tbl_left[TBL_DEPTH];
  bit        tbl_done[TBL_DEPTH];
  int        n_loaded = 0;
  int        run_idx = 0;
  bit        run_valid = 1'b0;
  bit [23:0] sched_now = '0;
  bit [31:0] wait_acc = '0;
  bit        policy = LARGER_WINS;

  // effective urgency under the current policy: bigger always wins
  function automatic bit [7:0] urgency(int k);
    return policy ? 8'd255 - tbl_prio[k] : tbl_prio[k];
  endfunction

  function automatic bit can_run(int k);
    return k < n_loaded && !tbl_done[k] && tbl_arr[k] <= sched_now;
  endfunction

  // Applies one accepted command; a tick queues the slot report it must produce.
  function automatic void sched_apply(sched_op_t op);
    int           k;
    int           best;
    bit           found;
    slot_report_t rpt;
    best = 0;
    found = 1'b0;
    rpt = '{default: 0};
    if (op.cmd == ppsched_pkg::CMD_LOAD) begin
      // full table drops the load; zero burst is stored as one
      if (n_loaded < TBL_DEPTH) begin
        tbl_prio[n_loaded]  = op.prio;
        tbl_arr[n_loaded]   = op.arrival;
        tbl_burst[n_loaded] = (op.burst == 0) ? 16'd1 : op.burst;
        tbl_left[n_loaded]  = tbl_burst[n_loaded];
        tbl_done[n_loaded]  = 1'b0;
        n_loaded++;
      end
      return;
    end
    // best urgency, then earliest arrival, then load order
    for (k = 0; k < n_loaded; k++) begin
      if (can_run(k) && (!found || urgency(k) > urgency(best) ||
          (urgency(k) == urgency(best) && tbl_arr[k] < tbl_arr[best]))) begin
        best = k;
        found = 1'b1;
      end
    end
    // running process keeps the CPU on an urgency tie
    if (found && run_valid && can_run(run_idx) && urgency(run_idx) == urgency(best))
      best = run_idx;
    if (sched_now != ppsched_pkg::TIME_MAX)
      sched_now++;
    if (found) begin
      run_idx = best;
      run_valid = 1'b1;
      if (tbl_left[best] > 0)
        tbl_left[best]--;
      if (tbl_left[best] == 0) begin
        tbl_done[best] = 1'b1;
        run_valid = 1'b0;
        rpt.fin = 1'b1;
        rpt.comp = sched_now;
        rpt.tat = (sched_now >= tbl_arr[best]) ? sched_now - tbl_arr[best] : '0;
        rpt.wt = (rpt.tat >= tbl_burst[best]) ? rpt.tat - tbl_burst[best] : '0;
        wait_acc = (wait_acc > ppsched_pkg::SUM_MAX - rpt.wt) ?
                   ppsched_pkg::SUM_MAX : wait_acc + rpt.wt;
      end
    end else begin
      run_valid = 1'b0;
    end
    rpt.idle = !found;
    rpt.proc_id = found ? best[3:0] : 4'd0;
    rpt.wsum = wait_acc;
    rpt.all_done = 1'b1;
    for (k = 0; k < n_loaded; k++)
      if (!tbl_done[k])
        rpt.all_done = 1'b0;
    slot_expect_q.push_back(rpt);
  endfunction

  // ------------------------------------------------------------------
  // Driver: bursts of commands with random gaps; policy writes only once
  // the scheduler has drained every outstanding tick
  // ------------------------------------------------------------------
  sched_op_t cur_op;
  bit        nxt_start;
  bit        nxt_cfg_valid;
  int        gap_left = 0;
  int        burst_left = 0;
  int        quiet = 0;

  always @(posedge clk) begin
    if (rst) begin
      start <= 1'b0;
      cfg_valid <= 1'b0;
      gap_left = 0;
      burst_left = 0;
      quiet = 0;
    end else begin
      nxt_start = start;
      nxt_cfg_valid = cfg_valid;
      if (start && !busy) begin
        sched_apply(cur_op);
        ops_done++;
        nxt_start = 1'b0;
        quiet = 0;
      end else if (quiet < WATCHDOG) begin
        quiet++;
      end
      if (cfg_valid && cfg_ready) begin
        policy = cfg_lower_value_first;
        ops_done++;
        nxt_cfg_valid = 1'b0;
      end
      if (!nxt_start && !nxt_cfg_valid && pending_ops.size() > 0) begin
        if (pending_ops[0].is_cfg) begin
          if (slot_expect_q.size() == 0 && quiet >= SETTLE) begin
            cur_op = pending_ops.pop_front();
            cfg_lower_value_first <= cur_op.cfg_val;
            nxt_cfg_valid = 1'b1;
          end
        end else if (gap_left > 0) begin
          gap_left--;
        end else begin
          cur_op = pending_ops.pop_front();
          cmd <= cur_op.cmd;
          proc_priority <= cur_op.prio;
          proc_arrival <= cur_op.arrival;
          proc_burst <= cur_op.burst;
          nxt_start = 1'b1;
          if (burst_left > 0)
            burst_left--;
          if (burst_left == 0) begin
            // next burst; about a third of them follow with no gap at all
            burst_left = $urandom_range(1, 24);
            gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 25);
          end
        end
      end
      start <= nxt_start;
      cfg_valid <= nxt_cfg_valid;
    end
  end

  // ------------------------------------------------------------------
  // Monitor: every strobed slot report against the oldest expectation
  // ------------------------------------------------------------------
  slot_report_t want;

  function automatic void check_field(string name, logic [31:0] exp_v, logic [31:0] got_v);
    if (got_v !== exp_v) begin
      $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, name, exp_v, got_v);
      err_count++;
    end
  endfunction

  always @(posedge clk) begin
    if (!rst && result_valid) begin
      if (slot_expect_q.size() == 0) begin
        $display("%0t ns: result transaction with none expected, slot_process %0d",
                 $time, slot_process);
        err_count++;
      end else begin
        want = slot_expect_q.pop_front();
        check_field("slot_idle", 32'(want.idle), 32'(slot_idle));
        check_field("slot_process", 32'(want.proc_id), 32'(slot_process));
        check_field("finished", 32'(want.fin), 32'(finished));
        check_field("finish_time", 32'(want.comp), 32'(finish_time));
        check_field("turnaround_time", 32'(want.tat), 32'(turnaround_time));
        check_field("wait_time", 32'(want.wt), 32'(wait_time));
        check_field("wait_total", want.wsum, wait_total);
        check_field("all_done", 32'(want.all_done), 32'(all_done));
      end
    end
  end

  // watchdog: cycles with no transaction of any kind
  always @(posedge clk) begin
    if (rst || (start && !busy) || (cfg_valid && cfg_ready) || result_valid)
      stall_cycles <= 0;
    else
      stall_cycles <= stall_cycles + 1;
  end

  // ------------------------------------------------------------------
  // Stimulus
  // ------------------------------------------------------------------
  int est_now = 0;   // scheduler clock as the queued ticks will leave it

  task automatic push_load(logic [7:0] p, logic [15:0] arr, logic [15:0] b);
    pending_ops.push_back('{is_cfg: 1'b0, cfg_val: 1'b0, cmd: ppsched_pkg::CMD_LOAD,
                            prio: p, arrival: arr, burst: b});
  endtask

  task automatic push_ticks(int n);
    repeat (n) begin
      pending_ops.push_back('{is_cfg: 1'b0, cfg_val: 1'b0, cmd: ppsched_pkg::CMD_TICK,
                              prio: 8'($urandom), arrival: 16'($urandom),
                              burst: 16'($urandom)});
      est_now++;
    end
  endtask

  task automatic push_cfg(bit v);
    pending_ops.push_back('{is_cfg: 1'b1, cfg_val: v, cmd: ppsched_pkg::CMD_TICK,
                            prio: '0, arrival: '0, burst: '0});
  endtask

  // random process, mostly arriving soon, priorities clustered to force ties
  task automatic push_random_load();
    logic [7:0]  p;
    logic [15:0] arr;
    logic [15:0] b;
    case ($urandom_range(0, 3))
      0:       p = ($urandom_range(0, 1) == 0) ? 8'd0 : 8'd255;
      1, 2:    p = 8'd100 + 8'($urandom_range(0, 2));
      default: p = 8'($urandom);
    endcase
    if ($urandom_range(0, 4) == 0)
      arr = (est_now > 20) ? 16'(est_now - $urandom_range(0, 20)) : 16'd0;
    else
      arr = 16'(est_now + $urandom_range(0, 60));
    b = ($urandom_range(0, 3) == 0) ? 16'($urandom_range(60, 250)) : 16'($urandom_range(1, 40));
    push_load(p, arr, b);
  endtask

  bit timed_out = 1'b0;

  initial begin
    // directed: idle tick on an empty table, zero burst, the two tie rules,
    // idle gap, late load that ends the idle gap, late tie that must not preempt,
    // a process that never arrives
    push_cfg(LARGER_WINS);
    push_ticks(1);
    push_load(8'd255, 16'd0, 16'd0);  // zero burst stored as one
    push_load(8'd10, 16'd2, 16'd3);   // ties with the next: load order decides
    push_load(8'd10, 16'd2, 16'd2);
    push_load(8'd10, 16'd1, 16'd2);   // same urgency, earlier arrival goes first
    push_ticks(8);
    push_load(8'd200, 16'd11, 16'd5); // late load, arrives after an idle stretch
    push_ticks(6);
    push_load(8'd200, 16'd0, 16'd2);  // equal urgency, earlier arrival: runner stays
    push_ticks(4);
    push_load(8'd128, 16'hFFFF, 16'hFFFF);  // never arrives, keeps all_done low

    // random phases, policy flipped between them; later loads hit a full table
    for (int ph = 0; ph < RAND_PHASES; ph++) begin
      push_cfg((ph % 2 == 0) ? SMALLER_WINS : LARGER_WINS);
      push_random_load();
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        if ($urandom_range(0, 99) < 3)
          push_random_load();
        else
          push_ticks(1);
      end
    end
    ops_total = pending_ops.size();

    repeat (8) @(posedge clk);
    rst <= 1'b0;

    while (!(ops_done == ops_total && slot_expect_q.size() == 0) && !timed_out) begin
      @(posedge clk);
      if (stall_cycles >= WATCHDOG)
        timed_out = 1'b1;
    end

    if (timed_out) begin
      $display("%0t ns: watchdog expired, %0d of %0d transactions done, %0d reports owed",
               $time, ops_done, ops_total, slot_expect_q.size());
      $display("[preemptive_priority_scheduler] ERROR");
    end else begin
      // catch any stray report after the last expected one
      repeat (SETTLE) @(posedge clk);
      if (err_count == 0)
        $display("[preemptive_priority_scheduler] OK");
      else
        $display("[preemptive_priority_scheduler] ERROR");
    end
    $finish;
  end

endmodule
